>>> sv/status_led_indicator_defines.svh
// ----------------------------------------------------------------------------
// Status LED indicator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_INDICATOR_DEFINES_SVH
`define STATUS_LED_INDICATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define SLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("status_led_indicator: assertion failed");

// Next-cycle implication, disabled while reset is active
`define SLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("status_led_indicator: assertion failed");

`endif

>>> sv/sli_pkg.sv
// ----------------------------------------------------------------------------
// Status LED indicator package
// Shared types, timing constants and fixed-point constants.
// ----------------------------------------------------------------------------
package sli_pkg;

	// Red blink queue
	localparam int RED_QUEUE_DEPTH = 4;
	localparam int RQ_IDX_W = (RED_QUEUE_DEPTH > 1) ? $clog2(RED_QUEUE_DEPTH) : 1;
	localparam int RQ_CNT_W = $clog2(RED_QUEUE_DEPTH + 1);
	localparam int RQ_SUM_W = RQ_IDX_W + 1;

	// Front-to-back work queue
	localparam int Q_DEPTH = 2;
	localparam int Q_IDX_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Items in flight: work queue, one in the back end, one in the output register
	localparam int CAPACITY = Q_DEPTH + 2;
	localparam int CAP_CNT_W = $clog2(CAPACITY + 1);

	// Times in microseconds
	localparam logic [31:0] US_250MS = 32'd250000;
	localparam logic [31:0] US_500MS = 32'd500000;
	localparam logic [31:0] US_1000MS = 32'd1000000;
	localparam logic [31:0] US_50MS = 32'd50000;
	localparam logic [31:0] US_1MS = 32'd1000;
	localparam logic [31:0] RED_WINDOW_RESET = US_1000MS;

	// Q3.13 constants
	localparam logic [15:0] Q_STEP = 16'd819;
	localparam logic [16:0] Q_TWO_PI = 17'd51472;
	localparam logic [16:0] Q_TWO_PI_X2 = 17'd102944;
	localparam int Q_FRAC = 13;

	// Datapath widths
	localparam int X2_W = 19;
	localparam int X3_W = 21;
	localparam int X5_W = 27;
	localparam int Q3_W = 19;
	localparam int Q5_W = 20;
	localparam int QR_W = 15;
	localparam int W_W = 24;
	localparam logic [W_W-1:0] W_ONE = 24'd8192;
	localparam logic [W_W-1:0] W_TWO = 24'd16384;

	// Shared multiplier
	localparam int MUL_A_W = 28;
	localparam int MUL_B_W = 22;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Reciprocals for division by constants (estimate low by at most one)
	localparam logic [MUL_B_W-1:0] REC6_M = 22'd349525;
	localparam int REC6_K = 21;
	localparam logic [MUL_B_W-1:0] REC120_M = 22'd1118481;
	localparam int REC120_K = 27;
	localparam logic [MUL_B_W-1:0] REC15625_M = 22'd17179;
	localparam int REC15625_K = 28;
	localparam logic [MUL_B_W-1:0] DIV15625 = 22'd15625;

	// Input codes
	localparam logic FUNC_TICK = 1'b1;
	localparam logic [3:0] EV_VOLT_LOW = 4'd0;
	localparam logic [3:0] EV_TEMP_HIGH = 4'd1;
	localparam logic [3:0] EV_HEARTBEAT = 4'd2;
	localparam logic [3:0] EV_ENGAGED = 4'd3;
	localparam logic [3:0] EV_DISENGAGED = 4'd4;
	localparam logic [3:0] EV_STUCK = 4'd5;
	localparam logic [3:0] EV_BOOTING = 4'd6;
	localparam logic [3:0] EV_INITIALIZED = 4'd7;
	localparam logic [3:0] EV_MESSAGE = 4'd8;

	// Classified work kinds
	typedef enum logic [3:0] {
		KIND_TICK,
		KIND_RED_SHORT,
		KIND_RED_LONG,
		KIND_HEARTBEAT,
		KIND_ENGAGE,
		KIND_DISENGAGE,
		KIND_STUCK,
		KIND_BOOT,
		KIND_INIT,
		KIND_MESSAGE,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [31:0] now_us;
	} work_t;

endpackage

>>> sv/sli_item_if.sv
// ----------------------------------------------------------------------------
// Status LED indicator input channel
// Valid/ready channel carrying one event or tick item.
// ----------------------------------------------------------------------------
interface sli_item_if;
	logic valid;
	logic ready;
	logic func;
	logic [3:0] event_code;
	logic [31:0] now_us;

	modport source(output valid, output func, output event_code, output now_us, input ready);
	modport sink(input valid, input func, input event_code, input now_us, output ready);
endinterface

>>> sv/sli_result_if.sv
// ----------------------------------------------------------------------------
// Status LED indicator result channel
// Valid/ready channel carrying the LED state after each item.
// ----------------------------------------------------------------------------
interface sli_result_if;
	logic valid;
	logic ready;
	logic accepted;
	logic red_on;
	logic [7:0] green_level;
	logic [7:0] yellow_level;
	logic blue_on;

	modport source(output valid, output accepted, output red_on, output green_level,
		output yellow_level, output blue_on, input ready);
	modport sink(input valid, input accepted, input red_on, input green_level,
		input yellow_level, input blue_on, output ready);
endinterface

>>> sv/sli_front.sv
// ----------------------------------------------------------------------------
// Status LED indicator front end
// Accepts items and classifies them into work kinds for the back end.
// ----------------------------------------------------------------------------
module sli_front (
	sli_item_if.sink items,
	output logic push_valid,
	input logic push_ready,
	output sli_pkg::work_t push_data
);

	// Pass the handshake through to the work queue
	assign items.ready = push_ready;
	assign push_valid = items.valid;

	// Classify the item
	always_comb begin
		push_data.now_us = items.now_us;
		if (items.func == sli_pkg::FUNC_TICK) begin
			push_data.kind = sli_pkg::KIND_TICK;
		end else begin
			case (items.event_code)
				sli_pkg::EV_VOLT_LOW: push_data.kind = sli_pkg::KIND_RED_SHORT;
				sli_pkg::EV_TEMP_HIGH: push_data.kind = sli_pkg::KIND_RED_LONG;
				sli_pkg::EV_HEARTBEAT: push_data.kind = sli_pkg::KIND_HEARTBEAT;
				sli_pkg::EV_ENGAGED: push_data.kind = sli_pkg::KIND_ENGAGE;
				sli_pkg::EV_DISENGAGED: push_data.kind = sli_pkg::KIND_DISENGAGE;
				sli_pkg::EV_STUCK: push_data.kind = sli_pkg::KIND_STUCK;
				sli_pkg::EV_BOOTING: push_data.kind = sli_pkg::KIND_BOOT;
				sli_pkg::EV_INITIALIZED: push_data.kind = sli_pkg::KIND_INIT;
				sli_pkg::EV_MESSAGE: push_data.kind = sli_pkg::KIND_MESSAGE;
				default: push_data.kind = sli_pkg::KIND_NONE;
			endcase
		end
	end

endmodule

>>> sv/sli_queue.sv
// ----------------------------------------------------------------------------
// Status LED indicator work queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module sli_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input sli_pkg::work_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output sli_pkg::work_t pop_data
);

	sli_pkg::work_t mem_q [sli_pkg::Q_DEPTH];
	logic [sli_pkg::Q_IDX_W-1:0] wr_ptr_q;
	logic [sli_pkg::Q_IDX_W-1:0] rd_ptr_q;
	logic [sli_pkg::Q_CNT_W-1:0] cnt_q;
	logic push_fire;
	logic pop_fire;

	assign push_ready = (cnt_q != sli_pkg::Q_CNT_W'(sli_pkg::Q_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_fire) begin
				if (wr_ptr_q == sli_pkg::Q_IDX_W'(sli_pkg::Q_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + sli_pkg::Q_IDX_W'(1);
				end
			end
			if (pop_fire) begin
				if (rd_ptr_q == sli_pkg::Q_IDX_W'(sli_pkg::Q_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + sli_pkg::Q_IDX_W'(1);
				end
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + sli_pkg::Q_CNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - sli_pkg::Q_CNT_W'(1);
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/sli_back.sv
// ----------------------------------------------------------------------------
// Status LED indicator back end
// Carries out events and ticks: red blink queue, green sine level on a shared
// multiplier, yellow and blue timers, and the output register.
// ----------------------------------------------------------------------------
module sli_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic work_valid,
	output logic work_ready,
	input sli_pkg::work_t work,
	sli_result_if.source results
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_X3,
		ST_X5,
		ST_D6,
		ST_D120,
		ST_DR,
		ST_RM,
		ST_RF,
		ST_FIN
	} state_t;

	state_t state_q;

	// Control state
	logic [31:0] red_window_q;
	logic [sli_pkg::RQ_IDX_W-1:0] rq_head_q;
	logic [sli_pkg::RQ_CNT_W-1:0] rq_cnt_q;
	logic [31:0] red_time_q;
	logic [15:0] phase_q;
	logic [15:0] step_q;
	logic half_q;
	logic [31:0] yellow_until_q;
	logic [31:0] blue_off_q;
	logic led_red_q;
	logic [7:0] led_green_q;
	logic led_yellow_q;
	logic led_blue_q;
	logic out_valid_q;

	// Datapath registers
	logic rq_mem_q [sli_pkg::RED_QUEUE_DEPTH];
	logic [31:0] now_q;
	logic red_div_q;
	logic [sli_pkg::MUL_P_W-1:0] prod_q;
	logic [sli_pkg::X2_W-1:0] x2_q;
	logic [sli_pkg::X3_W-1:0] x3_q;
	logic [sli_pkg::X5_W-1:0] x5_q;
	logic [sli_pkg::Q3_W-1:0] q3_q;
	logic [sli_pkg::Q5_W-1:0] q5_q;
	logic [sli_pkg::QR_W-1:0] qr_q;
	logic [sli_pkg::W_W-1:0] w_q;
	logic out_acc_q;
	logic out_red_q;
	logic [7:0] out_green_q;
	logic out_yellow_q;
	logic out_blue_q;

	// Combinational
	logic [31:0] now;
	logic slot_free;
	logic pop_fire;
	logic tick_fire;
	logic ev_fire;
	logic fin_fire;
	logic is_red_kind;
	logic [16:0] phase_sum;
	logic [15:0] phase_next;
	logic [31:0] red_dur;
	logic red_wait;
	logic red_idle;
	logic red_end;
	logic [sli_pkg::RQ_IDX_W-1:0] head_next;
	logic rq_full;
	logic [sli_pkg::RQ_SUM_W-1:0] push_sum;
	logic [sli_pkg::RQ_IDX_W-1:0] push_idx;
	logic [16:0] step_sum;
	logic [15:0] step_sat;
	logic ev_acc;
	logic blue_ev;
	logic [sli_pkg::X2_W-1:0] x2_w;
	logic [sli_pkg::X3_W-1:0] x3_w;
	logic [sli_pkg::X5_W-1:0] x5_w;
	logic [sli_pkg::Q3_W-1:0] q3_est;
	logic [sli_pkg::Q5_W-1:0] q5_est;
	logic [sli_pkg::QR_W-1:0] qr_est;
	logic [sli_pkg::X3_W-1:0] q3_x6;
	logic [sli_pkg::X3_W-1:0] r3;
	logic [sli_pkg::Q3_W-1:0] q3_fix;
	logic [sli_pkg::X5_W-1:0] q5_x120;
	logic [sli_pkg::X5_W-1:0] r5;
	logic [sli_pkg::Q5_W-1:0] q5_fix;
	logic [28:0] rr;
	logic [sli_pkg::QR_W-1:0] qr_fix;
	logic [sli_pkg::W_W-1:0] w_next;
	logic w_pos;
	logic [30:0] w_scaled;
	logic [15:0] lvl;
	logic [7:0] level;
	logic [sli_pkg::MUL_A_W-1:0] mul_a;
	logic [sli_pkg::MUL_B_W-1:0] mul_b;

	assign now = work.now_us;

	// Handshakes and fire strobes
	always_comb begin
		slot_free = !out_valid_q || results.ready;
		work_ready = (state_q == ST_IDLE) && ((work.kind == sli_pkg::KIND_TICK) || slot_free);
		pop_fire = work_valid && work_ready;
		tick_fire = pop_fire && (work.kind == sli_pkg::KIND_TICK);
		ev_fire = pop_fire && (work.kind != sli_pkg::KIND_TICK);
		fin_fire = (state_q == ST_FIN) && slot_free;
		is_red_kind = (work.kind == sli_pkg::KIND_RED_SHORT) ||
			(work.kind == sli_pkg::KIND_RED_LONG);
	end

	// Green phase advance, wrapped into 0..2*pi
	always_comb begin
		phase_sum = {1'b0, phase_q} + {1'b0, step_q};
		if (phase_sum >= sli_pkg::Q_TWO_PI_X2) begin
			phase_next = 16'(phase_sum - sli_pkg::Q_TWO_PI_X2);
		end else if (phase_sum >= sli_pkg::Q_TWO_PI) begin
			phase_next = 16'(phase_sum - sli_pkg::Q_TWO_PI);
		end else begin
			phase_next = phase_sum[15:0];
		end
	end

	// Red window decisions and queue indexes
	always_comb begin
		red_dur = rq_mem_q[rq_head_q] ? sli_pkg::US_1000MS : sli_pkg::US_500MS;
		red_wait = now < red_time_q;
		red_idle = (rq_cnt_q == '0);
		red_end = red_dur > now;
		if (rq_head_q == sli_pkg::RQ_IDX_W'(sli_pkg::RED_QUEUE_DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = rq_head_q + sli_pkg::RQ_IDX_W'(1);
		end
		rq_full = rq_cnt_q >= sli_pkg::RQ_CNT_W'(sli_pkg::RED_QUEUE_DEPTH);
		push_sum = sli_pkg::RQ_SUM_W'(rq_head_q) + sli_pkg::RQ_SUM_W'(rq_cnt_q);
		if (push_sum >= sli_pkg::RQ_SUM_W'(sli_pkg::RED_QUEUE_DEPTH)) begin
			push_idx = sli_pkg::RQ_IDX_W'(push_sum - sli_pkg::RQ_SUM_W'(sli_pkg::RED_QUEUE_DEPTH));
		end else begin
			push_idx = push_sum[sli_pkg::RQ_IDX_W-1:0];
		end
	end

	// Event outcome: heartbeat step, acceptance and blue LED
	always_comb begin
		step_sum = {1'b0, step_q} + {1'b0, sli_pkg::Q_STEP};
		step_sat = step_sum[16] ? 16'hFFFF : step_sum[15:0];
		ev_acc = !(is_red_kind && rq_full);
		case (work.kind)
			sli_pkg::KIND_BOOT: blue_ev = 1'b1;
			sli_pkg::KIND_MESSAGE: blue_ev = 1'b1;
			sli_pkg::KIND_INIT: blue_ev = 1'b0;
			default: blue_ev = led_blue_q;
		endcase
	end

	// Product slices and quotient corrections
	always_comb begin
		x2_w = prod_q[sli_pkg::Q_FRAC +: sli_pkg::X2_W];
		x3_w = prod_q[sli_pkg::Q_FRAC +: sli_pkg::X3_W];
		x5_w = prod_q[sli_pkg::Q_FRAC +: sli_pkg::X5_W];
		q3_est = prod_q[sli_pkg::REC6_K +: sli_pkg::Q3_W];
		q5_est = prod_q[sli_pkg::REC120_K +: sli_pkg::Q5_W];
		qr_est = prod_q[sli_pkg::REC15625_K +: sli_pkg::QR_W];

		q3_x6 = {q3_q, 2'b00} + {1'b0, q3_q, 1'b0};
		r3 = x3_q - q3_x6;
		q3_fix = q3_q + ((r3 >= sli_pkg::X3_W'(6)) ? sli_pkg::Q3_W'(1) : '0);

		q5_x120 = {q5_q, 7'b0} - {4'b0, q5_q, 3'b0};
		r5 = x5_q - q5_x120;
		q5_fix = q5_q + ((r5 >= sli_pkg::X5_W'(120)) ? sli_pkg::Q5_W'(1) : '0);

		rr = {1'b0, now_q[31:4]} - prod_q[28:0];
		qr_fix = qr_q + ((rr >= 29'(sli_pkg::DIV15625)) ? sli_pkg::QR_W'(1) : '0);
	end

	// Sine level: sum terms, scale by 255/32768, saturate
	always_comb begin
		w_next = sli_pkg::W_W'(phase_q) + sli_pkg::W_W'(q5_q) - sli_pkg::W_W'(q3_q) +
			(half_q ? sli_pkg::W_TWO : sli_pkg::W_ONE);
		w_pos = !w_q[sli_pkg::W_W-1] && (w_q != '0);
		w_scaled = {w_q[sli_pkg::W_W-2:0], 8'b0} - {8'b0, w_q[sli_pkg::W_W-2:0]};
		lvl = w_scaled[30:15];
		if (!w_pos) begin
			level = 8'd0;
		end else if (lvl > 16'd255) begin
			level = 8'd255;
		end else begin
			level = lvl[7:0];
		end
	end

	// Select shared multiplier operands
	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = sli_pkg::MUL_A_W'(phase_q);
				mul_b = sli_pkg::MUL_B_W'(phase_q);
			end
			ST_X3: begin
				mul_a = sli_pkg::MUL_A_W'(x2_w);
				mul_b = sli_pkg::MUL_B_W'(phase_q);
			end
			ST_X5: begin
				mul_a = sli_pkg::MUL_A_W'(x3_w);
				mul_b = sli_pkg::MUL_B_W'(x2_q);
			end
			ST_D6: begin
				mul_a = sli_pkg::MUL_A_W'(x3_q);
				mul_b = sli_pkg::REC6_M;
			end
			ST_D120: begin
				mul_a = sli_pkg::MUL_A_W'(x5_q);
				mul_b = sli_pkg::REC120_M;
			end
			ST_DR: begin
				mul_a = now_q[31:4];
				mul_b = sli_pkg::REC15625_M;
			end
			ST_RM: begin
				mul_a = sli_pkg::MUL_A_W'(qr_est);
				mul_b = sli_pkg::DIV15625;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer and LED state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			red_window_q <= sli_pkg::RED_WINDOW_RESET;
			rq_head_q <= '0;
			rq_cnt_q <= '0;
			red_time_q <= '0;
			phase_q <= '0;
			step_q <= '0;
			half_q <= 1'b0;
			yellow_until_q <= '0;
			blue_off_q <= '0;
			led_red_q <= 1'b0;
			led_green_q <= '0;
			led_yellow_q <= 1'b0;
			led_blue_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				red_window_q <= cfg_wdata;
			end

			// Hold the result until taken, then load the next one
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ev_fire || fin_fire) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (tick_fire) begin
						if (red_wait) begin
							led_red_q <= 1'b0;
						end else if (red_idle) begin
							red_time_q <= red_time_q + red_window_q;
						end else if (red_end) begin
							rq_head_q <= head_next;
							rq_cnt_q <= rq_cnt_q - sli_pkg::RQ_CNT_W'(1);
							led_red_q <= 1'b0;
							red_time_q <= red_time_q + red_window_q;
						end
						phase_q <= phase_next;
						step_q <= '0;
						led_yellow_q <= now < yellow_until_q;
						if (now > blue_off_q) begin
							led_blue_q <= 1'b0;
						end
						state_q <= ST_SQ;
					end else if (ev_fire) begin
						case (work.kind)
							sli_pkg::KIND_RED_SHORT, sli_pkg::KIND_RED_LONG: begin
								if (!rq_full) begin
									rq_cnt_q <= rq_cnt_q + sli_pkg::RQ_CNT_W'(1);
								end
							end
							sli_pkg::KIND_HEARTBEAT: step_q <= step_sat;
							sli_pkg::KIND_ENGAGE: half_q <= 1'b1;
							sli_pkg::KIND_DISENGAGE: half_q <= 1'b0;
							sli_pkg::KIND_STUCK: yellow_until_q <= now + sli_pkg::US_50MS;
							sli_pkg::KIND_BOOT, sli_pkg::KIND_INIT: led_blue_q <= blue_ev;
							sli_pkg::KIND_MESSAGE: begin
								led_blue_q <= blue_ev;
								blue_off_q <= now + sli_pkg::US_1MS;
							end
							default: ;
						endcase
					end
				end
				ST_SQ: state_q <= ST_X3;
				ST_X3: state_q <= ST_X5;
				ST_X5: state_q <= ST_D6;
				ST_D6: state_q <= ST_D120;
				ST_D120: state_q <= ST_DR;
				ST_DR: state_q <= ST_RM;
				ST_RM: state_q <= ST_RF;
				ST_RF: begin
					// Blink at 2 Hz: even quarter-seconds are on
					if (red_div_q) begin
						led_red_q <= ~qr_fix[0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						led_green_q <= level;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath and result payload
	always_ff @(posedge clk) begin
		prod_q <= sli_pkg::MUL_P_W'(mul_a) * sli_pkg::MUL_P_W'(mul_b);

		if (tick_fire) begin
			now_q <= now;
			red_div_q <= !red_wait && !red_idle && !red_end;
		end
		if (ev_fire && is_red_kind && !rq_full) begin
			rq_mem_q[push_idx] <= (work.kind == sli_pkg::KIND_RED_LONG);
		end

		case (state_q)
			ST_X3: x2_q <= x2_w;
			ST_X5: x3_q <= x3_w;
			ST_D6: x5_q <= x5_w;
			ST_D120: q3_q <= q3_est;
			ST_DR: begin
				q5_q <= q5_est;
				q3_q <= q3_fix;
			end
			ST_RM: begin
				qr_q <= qr_est;
				q5_q <= q5_fix;
			end
			ST_RF: w_q <= w_next;
			default: ;
		endcase

		if (ev_fire) begin
			out_acc_q <= ev_acc;
			out_red_q <= led_red_q;
			out_green_q <= led_green_q;
			out_yellow_q <= led_yellow_q;
			out_blue_q <= blue_ev;
		end else if (fin_fire) begin
			out_acc_q <= 1'b1;
			out_red_q <= led_red_q;
			out_green_q <= level;
			out_yellow_q <= led_yellow_q;
			out_blue_q <= led_blue_q;
		end
	end

	// Drive the result channel
	assign results.valid = out_valid_q;
	assign results.accepted = out_acc_q;
	assign results.red_on = out_red_q;
	assign results.green_level = out_green_q;
	assign results.yellow_level = {8{out_yellow_q}};
	assign results.blue_on = out_blue_q;

endmodule

>>> sv/status_led_indicator.sv
// ----------------------------------------------------------------------------
// Status LED indicator
// Drives red, green, yellow and blue status LEDs from event and tick items.
// ----------------------------------------------------------------------------
// Usage:
//   items   : valid/ready input; func selects event (0) or tick (1), with
//             event_code and now_us (microseconds).
//   results : valid/ready output; one result per item with the LED state
//             after that item and an accepted flag (0 when a red event found
//             the blink queue full).
//   cfg_we/cfg_wdata : writes red_window_us; write only while idle.
// Path: an event result is loaded into the output register when the back end takes
//   its item; a tick first steps through ST_SQ to ST_FIN on the one shared multiplier.
// Throughput: one event per cycle while the output register is free; a tick keeps
//   the back end busy through the seven products the sine level and blink phase take.
// Reset: the blink queue empties, all LEDs go off, timers and green phase
//   clear, red_window_us returns to 1000000.
// Stall: a result waits in the output register; the back end then halts at its next
//   event or in ST_FIN, and the two-entry work queue fills before items.ready drops.
// ----------------------------------------------------------------------------
module status_led_indicator (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	sli_item_if.sink items,
	sli_result_if.source results
);

	logic push_valid;
	logic push_ready;
	sli_pkg::work_t push_data;
	logic pop_valid;
	logic pop_ready;
	sli_pkg::work_t pop_data;

	sli_front u_front (
		.items(items),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	sli_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	sli_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.work_valid(pop_valid),
		.work_ready(pop_ready),
		.work(pop_data),
		.results(results)
	);

endmodule

>>> sv/sli_checker.sv
// ----------------------------------------------------------------------------
// Status LED indicator port checker
// Tracks items in flight at the ports and checks results against them.
// ----------------------------------------------------------------------------
`include "status_led_indicator_defines.svh"

module sli_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_accepted,
	input logic res_red_on,
	input logic [7:0] res_green_level,
	input logic [7:0] res_yellow_level,
	input logic res_blue_on
);

	logic [sli_pkg::CAP_CNT_W-1:0] outstanding_q;
	logic in_fire;
	logic out_fire;

	assign in_fire = item_valid && item_ready;
	assign out_fire = res_valid && res_ready;

	// Count items accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_fire && !out_fire) begin
			outstanding_q <= outstanding_q + sli_pkg::CAP_CNT_W'(1);
		end else if (out_fire && !in_fire) begin
			outstanding_q <= outstanding_q - sli_pkg::CAP_CNT_W'(1);
		end
	end

	// A result only ever answers an earlier item
	`SLI_ASSERT_IMP(a_result_has_item, clk, arst_n, res_valid, outstanding_q != '0)

	// Input backs off once every slot is taken
	`SLI_ASSERT_IMP(a_full_blocks_input, clk, arst_n,
		outstanding_q == sli_pkg::CAP_CNT_W'(sli_pkg::CAPACITY), !item_ready)

	// A stalled result holds
	`SLI_ASSERT_NXT(a_result_holds, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_accepted) && $stable(res_red_on) && $stable(res_green_level) && $stable(res_yellow_level) && $stable(res_blue_on))

endmodule

bind status_led_indicator sli_checker u_sli_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(items.valid),
	.item_ready(items.ready),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.res_accepted(results.accepted),
	.res_red_on(results.red_on),
	.res_green_level(results.green_level),
	.res_yellow_level(results.yellow_level),
	.res_blue_on(results.blue_on)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Status LED indicator testbench
// Sends event and tick items through the valid/ready channels with random
// gaps and stalls. It predicts the LED state after each item and checks every
// result field against it, across several red window settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sli_pkg::*;

	localparam logic FUNC_EVENT = 1'b0;
	// ticks ignore the event code
	localparam logic [3:0] TICK_CODE = 4'd0;
	localparam logic [3:0] EV_UNKNOWN_LOW = 4'd9;
	localparam logic [3:0] EV_UNKNOWN_HIGH = 4'd15;
	localparam int GAP_MAX = 18;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 105;
	localparam int DIRECTED_N = 23;
	localparam int WINDOW_SETTINGS = 5;

	typedef struct packed {
		logic accepted;
		logic red_on;
		logic [7:0] green_level;
		logic [7:0] yellow_level;
		logic blue_on;
	} led_out_t;

	typedef struct packed {
		logic func;
		logic [3:0] code;
		logic [31:0] now_us;
		logic typed;
		led_out_t want;
	} step_row_t;

	// green at level 63 from a zero phase, every other LED off
	localparam led_out_t BASE_LEDS = '{accepted: 1'b1, red_on: 1'b0, green_level: 8'd63,
		yellow_level: 8'd0, blue_on: 1'b0};
	localparam led_out_t REFUSED_LEDS = '{accepted: 1'b0, red_on: 1'b0, green_level: 8'd63,
		yellow_level: 8'd0, blue_on: 1'b0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	sli_item_if item_ch ();
	sli_result_if result_ch ();

	status_led_indicator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.items(item_ch),
		.results(result_ch)
	);

	// Predicted block state
	logic [31:0] window_us = RED_WINDOW_RESET;
	bit blink_long [RED_QUEUE_DEPTH];
	int unsigned blink_count = 0;
	int unsigned blink_head = 0;
	logic [31:0] red_phase_us = '0;
	int unsigned breathe_phase = 0;
	int unsigned breathe_step = 0;
	logic breathe_offset = 1'b0;
	logic [31:0] yellow_until_us = '0;
	logic [31:0] blue_off_us = '0;
	led_out_t lit = '0;

	led_out_t pending_leds[$];
	int unsigned fail_count = 0;
	int unsigned send_burst = 0;
	int unsigned take_burst = 0;
	int unsigned quiet_cycles = 0;

	step_row_t directed_rows [DIRECTED_N] = '{
		'{FUNC_TICK, TICK_CODE, 32'd0, 1'b1, BASE_LEDS},
		'{FUNC_EVENT, EV_VOLT_LOW, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_TEMP_HIGH, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_VOLT_LOW, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_TEMP_HIGH, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_VOLT_LOW, 32'd0, 1'b1, REFUSED_LEDS},
		'{FUNC_EVENT, EV_UNKNOWN_HIGH, 32'hFFFF_FFFF, 1'b1, BASE_LEDS},
		'{FUNC_EVENT, EV_UNKNOWN_LOW, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_ENGAGED, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_HEARTBEAT, 32'd0, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'd1000000, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'd400000, 1'b0, '0},
		'{FUNC_EVENT, EV_STUCK, 32'hFFFF_FFFF, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'd10000, 1'b0, '0},
		'{FUNC_EVENT, EV_MESSAGE, 32'hFFFF_FFFF, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'd500, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'd1000, 1'b0, '0},
		'{FUNC_EVENT, EV_BOOTING, 32'd0, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_INITIALIZED, 32'd0, 1'b0, '0},
		'{FUNC_EVENT, EV_DISENGAGED, 32'd0, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'hFFFF_FFFF, 1'b0, '0},
		'{FUNC_TICK, TICK_CODE, 32'd750000, 1'b0, '0}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Map a Q3.13 phase to a green level via the fifth-order sine polynomial
	function automatic logic [7:0] breathe_level(input int unsigned x, input logic offset);
		longint unsigned ux, sq, cube, fifth;
		longint w;
		ux = x;
		sq = (ux * ux) >> Q_FRAC;
		cube = (sq * ux) >> Q_FRAC;
		fifth = (cube * sq) >> Q_FRAC;
		w = longint'(ux) - longint'(cube / 6) + longint'(fifth / 120) + longint'(W_ONE);
		if (offset)
			w += longint'(W_ONE);
		if (w <= 0)
			return 8'd0;
		// scale 0..4 in Q3.13 onto 0..255
		w = (w * 255) >>> (Q_FRAC + 2);
		return (w > 255) ? 8'd255 : w[7:0];
	endfunction

	// Advance the predicted state by one item and return the LED result
	function automatic led_out_t predict_leds(input logic func, input logic [3:0] code,
			input logic [31:0] now);
		logic took;
		logic [31:0] dur_us;
		led_out_t res;
		took = 1'b1;
		if (func == FUNC_TICK) begin
			// red: hold off until the window, then drop or flash the queue head
			if (now < red_phase_us) begin
				lit.red_on = 1'b0;
			end else if (blink_count == 0) begin
				red_phase_us += window_us;
			end else begin
				dur_us = blink_long[blink_head] ? US_1000MS : US_500MS;
				if (dur_us > now) begin
					blink_head = (blink_head + 1) % RED_QUEUE_DEPTH;
					blink_count--;
					lit.red_on = 1'b0;
					red_phase_us += window_us;
				end else begin
					lit.red_on = (now % US_500MS) < US_250MS;
				end
			end
			// green: advance the breathing phase by the accumulated step
			breathe_phase = (breathe_phase + breathe_step) % Q_TWO_PI;
			lit.green_level = breathe_level(breathe_phase, breathe_offset);
			breathe_step = 0;
			lit.yellow_level = (now < yellow_until_us) ? 8'd255 : 8'd0;
			if (now > blue_off_us)
				lit.blue_on = 1'b0;
		end else begin
			case (code)
				EV_VOLT_LOW, EV_TEMP_HIGH: begin
					if (blink_count >= RED_QUEUE_DEPTH) begin
						took = 1'b0;
					end else begin
						blink_long[(blink_head + blink_count) % RED_QUEUE_DEPTH] =
							(code == EV_TEMP_HIGH);
						blink_count++;
					end
				end
				EV_HEARTBEAT: begin
					breathe_step += Q_STEP;
					if (breathe_step > 32'hFFFF)
						breathe_step = 32'hFFFF;
				end
				EV_ENGAGED: breathe_offset = 1'b1;
				EV_DISENGAGED: breathe_offset = 1'b0;
				EV_STUCK: yellow_until_us = now + US_50MS;
				EV_BOOTING: lit.blue_on = 1'b1;
				EV_INITIALIZED: lit.blue_on = 1'b0;
				EV_MESSAGE: begin
					lit.blue_on = 1'b1;
					blue_off_us = now + US_1MS;
				end
				default: ;
			endcase
		end
		res = lit;
		res.accepted = took;
		return res;
	endfunction

	// Draw idle cycles for one item, with occasional runs of back-to-back items
	function automatic int unsigned draw_gap(inout int unsigned burst_left);
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst_left = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, GAP_MAX);
	endfunction

	task automatic send_item(input logic func, input logic [3:0] code, input logic [31:0] now,
			input logic typed, input led_out_t want);
		int unsigned gap;
		led_out_t guess;
		gap = draw_gap(send_burst);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= func;
		item_ch.event_code <= code;
		item_ch.now_us <= now;
		do @(posedge clk); while (!item_ch.ready);
		guess = predict_leds(func, code, now);
		pending_leds.push_back(typed ? want : guess);
	endtask

	// Drop valid, wait for every result, then let the back end go quiet
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (pending_leds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_us = value;
	endtask

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Result side: stall at random, then take one item
	initial begin
		int unsigned stall;
		result_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap(take_burst);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		led_out_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_leds.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time,
					{result_ch.accepted, result_ch.red_on, result_ch.green_level,
					result_ch.yellow_level, result_ch.blue_on});
				fail_count++;
			end else begin
				want = pending_leds.pop_front();
				check_field("accepted", 8'(want.accepted), 8'(result_ch.accepted));
				check_field("red_on", 8'(want.red_on), 8'(result_ch.red_on));
				check_field("green_level", want.green_level, result_ch.green_level);
				check_field("yellow_level", want.yellow_level, result_ch.yellow_level);
				check_field("blue_on", 8'(want.blue_on), 8'(result_ch.blue_on));
			end
		end
	end

	// Stop a hung run: count cycles with no item moving on either side
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL status_led_indicator");
			$finish;
		end
	end

	// Stimulus: directed table, then random phases under several red windows
	initial begin
		logic [31:0] clock_us;
		logic [31:0] windows [WINDOW_SETTINGS];
		int unsigned pick;
		step_row_t row;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_EVENT;
		item_ch.event_code = TICK_CODE;
		item_ch.now_us = '0;
		windows[0] = 32'd1;
		windows[1] = 32'hFFFF_FFFF;
		windows[2] = US_250MS;
		windows[3] = US_1000MS;
		windows[4] = $urandom_range(1, 3000000);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_window(windows[0]);

		for (int i = 0; i < DIRECTED_N; i++) begin
			row = directed_rows[i];
			send_item(row.func, row.code, row.now_us, row.typed, row.want);
		end

		for (int p = 0; p < WINDOW_SETTINGS; p++) begin
			if (p != 0) begin
				drain_results();
				write_window(windows[p]);
			end
			// one phase starts the clock just below the 32-bit wrap
			clock_us = (p == 1) ? 32'hFFF0_0000 : $urandom_range(0, 300000);
			// saturate the green step with a long run of heartbeats
			if (p == 0)
				repeat ($urandom_range(81, 90))
					send_item(FUNC_EVENT, EV_HEARTBEAT, clock_us, 1'b0, '0);
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					clock_us += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) :
						$urandom_range(0, 40000);
					send_item(FUNC_TICK, 4'($urandom_range(0, 15)), clock_us, 1'b0, '0);
				end else if (pick < 60) begin
					send_item(FUNC_EVENT, $urandom_range(0, 1) ? EV_TEMP_HIGH : EV_VOLT_LOW,
						clock_us, 1'b0, '0);
				end else if (pick < 70) begin
					send_item(FUNC_EVENT, EV_HEARTBEAT, clock_us, 1'b0, '0);
				end else if (pick < 76) begin
					send_item(FUNC_EVENT, $urandom_range(0, 1) ? EV_ENGAGED : EV_DISENGAGED,
						clock_us, 1'b0, '0);
				end else if (pick < 82) begin
					send_item(FUNC_EVENT, EV_STUCK, clock_us, 1'b0, '0);
				end else if (pick < 92) begin
					case ($urandom_range(0, 2))
						0: send_item(FUNC_EVENT, EV_BOOTING, clock_us, 1'b0, '0);
						1: send_item(FUNC_EVENT, EV_INITIALIZED, clock_us, 1'b0, '0);
						default: send_item(FUNC_EVENT, EV_MESSAGE, clock_us, 1'b0, '0);
					endcase
				end else begin
					// noise: any function, any code, any time
					send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom,
						1'b0, '0);
				end
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("PASS status_led_indicator");
		else
			$display("FAIL status_led_indicator");
		$finish;
	end

endmodule

>>> status_led_indicator.f
+incdir+sv
sv/sli_pkg.sv
sv/sli_item_if.sv
sv/sli_result_if.sv
sv/sli_front.sv
sv/sli_queue.sv
sv/sli_back.sv
sv/status_led_indicator.sv
sv/sli_checker.sv
dv/testbench.sv
